/* rtl/fsf_pkg.sv */
// ----------------------------------------------------------------------------
// fsf_pkg
// shared types, constants and fixed-point helpers of the frequency sampling
// filter
// ----------------------------------------------------------------------------
package fsf_pkg;

    localparam int COMB_LEN_DEF = 64;
    localparam int MAX_RES_DEF  = 33;

    localparam int SAMPLE_W = 16;
    localparam int FACTOR_W = 17;
    localparam int COEF_W   = 18;
    localparam int STATE_W  = 32;
    localparam int OP_B_W   = 32;
    localparam int PROD_W   = COEF_W + OP_B_W;
    localparam int D_W      = 18;
    localparam int U_W      = 20;
    localparam int FB_W     = PROD_W + 1;
    localparam int CNT6_W   = 6;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // register indexes, one word apart
    localparam logic [2:0] REG_COMB_N_FACTOR = 3'd0;
    localparam logic [2:0] REG_COMB2_FACTOR  = 3'd1;
    localparam logic [2:0] REG_RES_COUNT     = 3'd2;
    localparam logic [2:0] REG_RES_INDEX     = 3'd3;
    localparam logic [2:0] REG_RES_COEFF1    = 3'd4;
    localparam logic [2:0] REG_RES_COEFF2    = 3'd5;
    localparam logic [2:0] REG_RES_GAIN      = 3'd6;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LMUL,
        S_SMUL,
        S_SADD,
        S_RA,
        S_RB,
        S_RF,
        S_RY,
        S_RG,
        S_RACC,
        S_OUT
    } fsf_state_t;

    typedef struct packed {
        logic signed [FACTOR_W-1:0] comb_n_factor;
        logic signed [FACTOR_W-1:0] comb2_factor;
        logic        [CNT6_W-1:0]   res_count;
    } fsf_cfg_t;

    typedef struct packed {
        logic                       we;
        logic        [CNT6_W-1:0]   index;
        logic signed [COEF_W-1:0]   a;
        logic signed [FACTOR_W-1:0] b;
        logic signed [COEF_W-1:0]   gain;
    } fsf_coef_wr_t;

    // add half an lsb and shift right by 16, rounding to nearest with ties toward plus infinity
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + 64'sd32768;
        return t >>> 16;
    endfunction

    // saturate to a w-bit signed range
    function automatic logic signed [63:0] sat_w(input logic signed [63:0] v,
                                                 input int w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

/* rtl/fsf_mul.sv */
// ----------------------------------------------------------------------------
// fsf_mul
// shared signed 18 x 32 multiplier with registered product
// ----------------------------------------------------------------------------
module fsf_mul
    import fsf_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [COEF_W-1:0] op_a,
    input  logic signed [OP_B_W-1:0] op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

/* rtl/fsf_apb_regs.sv */
// ----------------------------------------------------------------------------
// fsf_apb_regs
// configuration registers behind the apb port, gain write commits an entry
// ----------------------------------------------------------------------------
module fsf_apb_regs
    import fsf_pkg::*;
#(
    parameter int MAX_RES = MAX_RES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output fsf_cfg_t           cfg,
    output fsf_coef_wr_t       coef_wr
);

    logic signed [FACTOR_W-1:0] comb_n_reg;
    logic signed [FACTOR_W-1:0] comb2_reg;
    logic        [CNT6_W-1:0]   count_reg;
    logic        [CNT6_W-1:0]   index_reg;
    logic signed [COEF_W-1:0]   coeff1_reg;
    logic signed [FACTOR_W-1:0] coeff2_reg;
    logic signed [COEF_W-1:0]   gain_reg;
    logic                       wr_en;
    logic        [2:0]          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            comb_n_reg <= '0;
            comb2_reg  <= '0;
            count_reg  <= '0;
            index_reg  <= '0;
            coeff1_reg <= '0;
            coeff2_reg <= '0;
            gain_reg   <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_COMB_N_FACTOR: comb_n_reg <= pwdata[FACTOR_W-1:0];
                REG_COMB2_FACTOR:  comb2_reg  <= pwdata[FACTOR_W-1:0];
                REG_RES_COUNT:     count_reg  <= pwdata[CNT6_W-1:0];
                REG_RES_INDEX:     index_reg  <= pwdata[CNT6_W-1:0];
                REG_RES_COEFF1:    coeff1_reg <= pwdata[COEF_W-1:0];
                REG_RES_COEFF2:    coeff2_reg <= pwdata[FACTOR_W-1:0];
                REG_RES_GAIN:      gain_reg   <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_COMB_N_FACTOR: prdata = DATA_W'($unsigned(comb_n_reg));
            REG_COMB2_FACTOR:  prdata = DATA_W'($unsigned(comb2_reg));
            REG_RES_COUNT:     prdata = DATA_W'(count_reg);
            REG_RES_INDEX:     prdata = DATA_W'(index_reg);
            REG_RES_COEFF1:    prdata = DATA_W'($unsigned(coeff1_reg));
            REG_RES_COEFF2:    prdata = DATA_W'($unsigned(coeff2_reg));
            REG_RES_GAIN:      prdata = DATA_W'($unsigned(gain_reg));
            default:           prdata = '0;
        endcase
    end

    assign cfg.comb_n_factor = comb_n_reg;
    assign cfg.comb2_factor  = comb2_reg;
    assign cfg.res_count     = count_reg;

    // entries past the table are dropped
    assign coef_wr.we    = wr_en && (idx == REG_RES_GAIN) && (32'(index_reg) < MAX_RES);
    assign coef_wr.index = index_reg;
    assign coef_wr.a     = coeff1_reg;
    assign coef_wr.b     = coeff2_reg;
    assign coef_wr.gain  = pwdata[COEF_W-1:0];

endmodule

/* rtl/frequency_sampling_filter.sv */
// ----------------------------------------------------------------------------
// frequency_sampling_filter
// type iv frequency sampling filter: long comb, two-tap comb, resonator bank
// ----------------------------------------------------------------------------
// One sample in, one sample out. Every product goes through one shared
// 18 x 32 multiplier driven by a small sequencer. For each item it does
// the comb work (long comb product, two-tap comb product, sum), then for
// each active resonator (res_count, capped at MAX_RES) two feedback
// products, sum, saturate, gain product and accumulate, and last loads
// the output register, waiting there while the old result is not taken.
// s_tready is high only while the sequencer is idle, so a new sample is
// not accepted before the last one is loaded into the output register; a
// finished sample waits in the output register and does not block the next
// accept. After reset the delay line and resonator state memories are
// cleared, during which no sample is taken;
// apb writes are taken at any time. The coefficient table is not cleared:
// every active entry must be written (res_index, res_coeff1, res_coeff2,
// then res_gain) before use.
// ----------------------------------------------------------------------------
module frequency_sampling_filter
    import fsf_pkg::*;
#(
    parameter int COMB_LEN = COMB_LEN_DEF,
    parameter int MAX_RES  = MAX_RES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input sample channel
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [15:0] sample_in
    // result channel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [15:0] sample_out
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int LONG_AW = $clog2(COMB_LEN);
    localparam int RES_AW  = $clog2(MAX_RES);
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int CLR_LEN = (COMB_LEN > MAX_RES) ? COMB_LEN : MAX_RES;
    localparam int CLR_W   = $clog2(CLR_LEN);
    localparam int ACC_W   = PROD_W + CNT_W;
    localparam int CE_W    = 2 * COEF_W + FACTOR_W;

    // configuration
    fsf_cfg_t     cfg;
    fsf_coef_wr_t coef_wr;

    fsf_apb_regs #(
        .MAX_RES (MAX_RES)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .coef_wr (coef_wr)
    );

    // shared multiplier
    logic signed [COEF_W-1:0] mul_a;
    logic signed [OP_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;

    fsf_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // sequencer state
    fsf_state_t state_reg, state_next;
    logic [CLR_W-1:0]   clr_cnt_reg;
    logic [LONG_AW-1:0] long_pos_reg;
    logic               short_pos_reg;
    logic [CNT_W-1:0]   k_reg;
    logic [CNT_W-1:0]   k_plus;
    logic [CNT_W-1:0]   n_act;
    logic               clr_done;
    logic               out_free;

    // datapath registers
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [D_W-1:0]      d_reg;
    logic signed [U_W-1:0]      u_reg;
    logic signed [FB_W-1:0]     fb_reg;
    logic signed [STATE_W-1:0]  y_reg;
    logic signed [STATE_W-1:0]  y_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [D_W-1:0]      short_reg [2];
    logic                       m_valid_reg;
    logic [SAMPLE_W-1:0]        m_data_reg;

    // memories
    logic [SAMPLE_W-1:0]    long_mem  [COMB_LEN];
    logic [2*STATE_W-1:0]   state_mem [MAX_RES];
    logic [CE_W-1:0]        coef_mem  [MAX_RES];
    logic signed [SAMPLE_W-1:0] long_rd;
    logic [2*STATE_W-1:0]   state_rd;
    logic [CE_W-1:0]        coef_rd;
    logic [RES_AW-1:0]      res_rd_addr;

    // combinational control
    logic                   long_we;
    logic [LONG_AW-1:0]     long_waddr;
    logic [SAMPLE_W-1:0]    long_wdata;
    logic                   state_we;
    logic [RES_AW-1:0]      state_waddr;
    logic [2*STATE_W-1:0]   state_wdata;

    // unpacked table and state words
    logic signed [COEF_W-1:0]   coef_a;
    logic signed [FACTOR_W-1:0] coef_b;
    logic signed [COEF_W-1:0]   coef_g;
    logic signed [STATE_W-1:0]  y1_rd;
    logic signed [STATE_W-1:0]  y2_rd;

    assign coef_a = coef_rd[COEF_W-1:0];
    assign coef_b = coef_rd[COEF_W+FACTOR_W-1:COEF_W];
    assign coef_g = coef_rd[CE_W-1:COEF_W+FACTOR_W];
    assign y1_rd  = state_rd[STATE_W-1:0];
    assign y2_rd  = state_rd[2*STATE_W-1:STATE_W];

    // active resonators, capped at the table depth
    assign n_act    = (32'(cfg.res_count) > MAX_RES) ? CNT_W'(MAX_RES)
                                                     : CNT_W'(cfg.res_count);
    assign k_plus   = k_reg + CNT_W'(1);
    assign clr_done = (clr_cnt_reg == CLR_W'(CLR_LEN - 1));
    assign out_free = !m_valid_reg || m_tready;

    // resonator output: feedback rounded, added to the comb output, saturated
    always_comb begin
        logic signed [63:0] t;
        t = 64'(u_reg) + rnd16(64'(fb_reg));
        y_next = STATE_W'(sat_w(t, STATE_W));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_done) state_next = S_IDLE;
            S_IDLE:  if (s_tvalid) state_next = S_LMUL;
            S_LMUL:  state_next = S_SMUL;
            S_SMUL:  state_next = S_SADD;
            S_SADD:  state_next = (n_act == '0) ? S_OUT : S_RA;
            S_RA:    state_next = S_RB;
            S_RB:    state_next = S_RF;
            S_RF:    state_next = S_RY;
            S_RY:    state_next = S_RG;
            S_RG:    state_next = S_RACC;
            S_RACC:  state_next = (k_plus == n_act) ? S_OUT : S_RA;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    // sequencer outputs: multiplier operands, memory ports
    always_comb begin
        mul_a       = '0;
        mul_b       = '0;
        long_we     = 1'b0;
        long_waddr  = long_pos_reg;
        long_wdata  = x_reg;
        state_we    = 1'b0;
        state_waddr = k_reg[RES_AW-1:0];
        state_wdata = {y1_rd, y_next};
        res_rd_addr = k_reg[RES_AW-1:0];
        unique case (state_reg)
            S_CLEAR: begin
                long_we     = 32'(clr_cnt_reg) < COMB_LEN;
                long_waddr  = LONG_AW'(clr_cnt_reg);
                long_wdata  = '0;
                state_we    = 32'(clr_cnt_reg) < MAX_RES;
                state_waddr = RES_AW'(clr_cnt_reg);
                state_wdata = '0;
            end
            S_LMUL: begin
                mul_a   = COEF_W'(cfg.comb_n_factor);
                mul_b   = OP_B_W'(long_rd);
                long_we = 1'b1;
            end
            S_SMUL: begin
                mul_a = COEF_W'(cfg.comb2_factor);
                mul_b = OP_B_W'(short_reg[short_pos_reg]);
            end
            S_SADD: res_rd_addr = '0;
            S_RA: begin
                mul_a = coef_a;
                mul_b = y1_rd;
            end
            S_RB: begin
                mul_a = COEF_W'(coef_b);
                mul_b = y2_rd;
            end
            S_RY:    state_we = 1'b1;
            S_RG: begin
                mul_a = coef_g;
                mul_b = y_reg;
            end
            S_RACC:  res_rd_addr = k_plus[RES_AW-1:0];
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            long_pos_reg  <= '0;
            short_pos_reg <= 1'b0;
            k_reg         <= '0;
            m_valid_reg   <= 1'b0;
            short_reg[0]  <= '0;
            short_reg[1]  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            end
            if (state_reg == S_LMUL) begin
                long_pos_reg <= (32'(long_pos_reg) == COMB_LEN - 1) ? '0
                                : long_pos_reg + LONG_AW'(1);
            end
            if (state_reg == S_SADD) begin
                short_reg[short_pos_reg] <= d_reg;
                short_pos_reg            <= !short_pos_reg;
                k_reg                    <= '0;
            end
            if (state_reg == S_RACC) begin
                k_reg <= k_plus;
            end
            // output register: a new result loads as the old one leaves
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        logic signed [63:0] t;
        t = '0;
        unique case (state_reg)
            S_IDLE: x_reg <= s_tdata;
            S_SMUL: begin
                // long comb output, saturated to 18 bits
                t     = 64'(x_reg) + rnd16(64'(prod));
                d_reg <= D_W'(sat_w(t, D_W));
            end
            S_SADD: begin
                t       = 64'(d_reg) + rnd16(64'(prod));
                u_reg   <= U_W'(t);
                acc_reg <= '0;
            end
            S_RB:   fb_reg  <= FB_W'(prod);
            S_RF:   fb_reg  <= fb_reg + FB_W'(prod);
            S_RY:   y_reg   <= y_next;
            S_RACC: acc_reg <= acc_reg + ACC_W'(prod);
            S_OUT: begin
                if (out_free) begin
                    t          = sat_w(rnd16(64'(acc_reg)), SAMPLE_W);
                    m_data_reg <= t[SAMPLE_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // delay line memory, registered read at the current position
    always_ff @(posedge aclk) begin
        if (long_we) begin
            long_mem[long_waddr] <= long_wdata;
        end
        long_rd <= long_mem[long_pos_reg];
    end

    // resonator state memory, {y2, y1} per entry
    always_ff @(posedge aclk) begin
        if (state_we) begin
            state_mem[state_waddr] <= state_wdata;
        end
        state_rd <= state_mem[res_rd_addr];
    end

    // coefficient table, {gain, b, a} per entry, written from the apb side
    always_ff @(posedge aclk) begin
        if (coef_wr.we) begin
            coef_mem[RES_AW'(coef_wr.index)] <= {coef_wr.gain, coef_wr.b, coef_wr.a};
        end
        coef_rd <= coef_mem[res_rd_addr];
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
